>>> design/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 11;
  localparam int OP_W      = 2;
  localparam int STS_W     = 2;
  localparam int MARK_W    = 2;
  localparam int MAX_SLOTS = 1024;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STS_W-1:0]  sts_t;
  typedef logic [MARK_W-1:0] mark_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_QUERY  = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  localparam sts_t STS_OK      = 2'd0;
  localparam sts_t STS_DUP     = 2'd1;
  localparam sts_t STS_FULL    = 2'd2;
  localparam sts_t STS_MISSING = 2'd3;

  localparam mark_t MARK_EMPTY = 2'd0;
  localparam mark_t MARK_FULL  = 2'd1;
  localparam mark_t MARK_TOMB  = 2'd2;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_PRD   = 6'b001000,
    ST_PCHK  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic div_step;
    logic probe_chk;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic early_done;
    logic exhausted;
    logic chk_done;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> design/lpht_ram.sv
// Generic single-port RAM with registered read data.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> design/lpht_ctrl.sv
// Controller state machine for the hash table.
module lpht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpht_pkg::dp_stat_t stat_i,
  output lpht_pkg::ctrl_cmd_t cmd_o
);
  import lpht_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.early_done ? ST_RESP : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_PRD;
      end
      ST_PRD: begin
        state_d = stat_i.exhausted ? ST_RESP : ST_PCHK;
      end
      ST_PCHK: begin
        cmd_o.probe_chk = 1'b1;
        state_d = stat_i.chk_done ? ST_RESP : ST_PRD;
      end
      ST_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q != ST_IDLE)
    else $error("idle after accept");

  a_chk_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PCHK |-> $past(state_q) == ST_PRD)
    else $error("check without read");

  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> state_q == ST_IDLE)
    else $error("result load did not return to idle");
endmodule

>>> design/lpht_dp.sv
// Datapath: key remainder unit, probe registers, slot RAM and result registers.
module lpht_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpht_pkg::CNT_W-1:0]    nb_i,
  input  lpht_pkg::ctrl_cmd_t           cmd_i,
  output lpht_pkg::dp_stat_t            stat_o,
  input  logic [lpht_pkg::OP_W-1:0]     opcode_i,
  input  logic signed [lpht_pkg::KEY_W-1:0] key_in_i,
  input  logic [lpht_pkg::VAL_W-1:0]    value_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lpht_pkg::STS_W-1:0]    status_o,
  output logic [lpht_pkg::VAL_W-1:0]    value_out_o,
  output logic [lpht_pkg::CNT_W-1:0]    miss_count_o
);
  import lpht_pkg::*;

  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int DC_W  = $clog2(KEY_W);
  localparam int ROW_W = MARK_W + KEY_W + VAL_W;

  op_t              op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [KEY_W-1:0] dvd_q;
  logic [CNT_W-1:0] rem_q;
  logic             neg_q;
  logic [DC_W-1:0]  bit_q;
  logic [SW-1:0]    pos_q;
  logic [CNT_W-1:0] miss_q;
  logic [CNT_W-1:0] rec_q;
  logic [SW-1:0]    clr_q;
  sts_t             res_sts_q;
  logic [VAL_W-1:0] res_val_q;
  sts_t             out_sts_q;
  logic [VAL_W-1:0] out_val_q;
  logic [CNT_W-1:0] out_miss_q;
  logic             out_vld_q;

  // remainder step, one dividend bit per cycle
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W-1:0] rem_nx;
  logic [CNT_W-1:0] home;
  logic [KEY_W-1:0] mag;

  assign mag    = key_in_i[KEY_W-1] ? KEY_W'(-key_in_i) : KEY_W'(key_in_i);
  assign rem_sh = {rem_q, dvd_q[KEY_W-1]};
  assign rem_nx = (rem_sh >= {1'b0, nb_i}) ? CNT_W'(rem_sh - {1'b0, nb_i}) : CNT_W'(rem_sh);
  assign home   = (neg_q && rem_nx != '0) ? nb_i - rem_nx : rem_nx;

  // slot RAM
  logic             ram_we;
  logic [SW-1:0]    ram_addr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  mark_t            rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  assign rd_mark = ram_rdata[ROW_W-1 -: MARK_W];
  assign rd_key  = ram_rdata[VAL_W +: KEY_W];
  assign rd_val  = ram_rdata[VAL_W-1:0];

  logic             chk_done, chk_wr, key_eq, is_full, hit;
  sts_t             chk_sts;
  logic [VAL_W-1:0] chk_val;

  always_comb begin
    key_eq  = (rd_key == key_q);
    is_full = (rd_mark == MARK_FULL);
    hit     = is_full && key_eq;
    chk_val = '0;
    if (op_q == OP_INSERT) begin
      chk_done = !is_full || key_eq;
      chk_wr   = !is_full;
      chk_sts  = !is_full ? STS_OK : STS_DUP;
    end else begin
      chk_done = hit || (rd_mark == MARK_EMPTY);
      chk_wr   = hit && (op_q == OP_REMOVE);
      chk_sts  = hit ? STS_OK : STS_MISSING;
      if (hit && op_q == OP_QUERY) chk_val = rd_val;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pos_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we   = 1'b1;
      ram_addr = clr_q;
    end else if (cmd_i.probe_chk && chk_wr) begin
      ram_we    = 1'b1;
      ram_wdata = (op_q == OP_INSERT) ? {MARK_FULL, key_q, val_q} : {MARK_TOMB, rd_key, rd_val};
    end
  end

  lpht_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SLOTS)) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic [SW:0]   pos_inc;
  logic [SW-1:0] pos_nx;
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign pos_nx  = (32'(pos_inc) == 32'(nb_i)) ? '0 : SW'(pos_inc);

  assign stat_o.clr_last   = (32'(clr_q) == MAX_SLOTS - 1);
  assign stat_o.div_last   = (bit_q == DC_W'(KEY_W - 1));
  assign stat_o.early_done = (opcode_i == OP_UNUSED) || (opcode_i == OP_INSERT && rec_q >= nb_i);
  assign stat_o.exhausted  = (miss_q == nb_i);
  assign stat_o.chk_done   = chk_done;
  assign stat_o.out_busy   = out_vld_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= opcode_i;
      key_q     <= key_in_i;
      val_q     <= value_in_i;
      dvd_q     <= mag;
      neg_q     <= key_in_i[KEY_W-1];
      rem_q     <= '0;
      bit_q     <= '0;
      miss_q    <= '0;
      res_val_q <= '0;
      res_sts_q <= (opcode_i == OP_INSERT) ? STS_FULL : STS_MISSING;
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_nx;
      bit_q <= bit_q + 1'b1;
      if (stat_o.div_last) pos_q <= SW'(home);
    end
    if (cmd_i.probe_chk) begin
      if (chk_done) begin
        res_sts_q <= chk_sts;
        res_val_q <= chk_val;
      end else begin
        pos_q  <= pos_nx;
        miss_q <= miss_q + 1'b1;
      end
    end
    if (cmd_i.res_load) begin
      out_sts_q  <= res_sts_q;
      out_val_q  <= res_val_q;
      out_miss_q <= miss_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q     <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.probe_chk && chk_wr) begin
        if (op_q == OP_INSERT) begin
          rec_q <= rec_q + 1'b1;
        end else if (rec_q != '0) begin
          rec_q <= rec_q - 1'b1;
        end
      end
      if (cmd_i.res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = out_sts_q;
  assign value_out_o  = out_val_q;
  assign miss_count_o = out_miss_q;

  a_miss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> miss_q <= nb_i)
    else $error("miss count past bucket count");
endmodule

>>> design/linear_probe_hash_table.sv
// Top level of the linear probing hash table with tombstones.
// Open-addressing table: each transfer is an insert, query or remove of a
// signed 32-bit key, answered by one result transfer (status, value, misses).
// After reset the block sweeps the slot RAM to mark all slots empty, one slot
// per cycle, and holds in_stall_o high meanwhile (APB writes are taken as
// usual). Per item: the accept, the bit-serial key remainder, then a RAM read
// and a check for each probed slot, then the load of the output register. A
// walk ends at the slot that settles it or when a whole pass runs out; opcode
// 3 and an insert into a full table go from the accept straight to the load.
// The single-port slot RAM with its registered read is why each probed slot
// needs a read step and a check step. One item is worked at a time; a result
// waiting in the output register does not block the next accept, but the load
// of the following result waits until it has left.
// bucket_count sits at byte address 0; it is to be written only while idle,
// which the block itself does not enforce.
module linear_probe_hash_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lpht_pkg::OP_W-1:0]         opcode_i,
  input  logic signed [lpht_pkg::KEY_W-1:0] key_in_i,
  input  logic [lpht_pkg::VAL_W-1:0]        value_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lpht_pkg::STS_W-1:0]        status_o,
  output logic [lpht_pkg::VAL_W-1:0]        value_out_o,
  output logic [lpht_pkg::CNT_W-1:0]        miss_count_o
);
  import lpht_pkg::*;

  localparam logic [CNT_W-1:0] BUCKET_RST = 11'd1021;

  logic [CNT_W-1:0] bucket_q;
  logic [CNT_W-1:0] nb;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  // register file: one register at word 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(bucket_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q <= BUCKET_RST;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      bucket_q <= pwdata[CNT_W-1:0];
    end
  end

  // effective bucket count: zero acts as one, clamp to the slot RAM depth
  always_comb begin
    if (bucket_q == '0) begin
      nb = CNT_W'(1);
    end else if (32'(bucket_q) > MAX_SLOTS) begin
      nb = CNT_W'(MAX_SLOTS);
    end else begin
      nb = bucket_q;
    end
  end

  lpht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lpht_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nb_i        (nb),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .opcode_i    (opcode_i),
    .key_in_i    (key_in_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .miss_count_o(miss_count_o)
  );
endmodule
